FILE: rtl/core/rlecdc_pkg.sv
//------------------------------------------------------------------------------
// rlecdc_pkg
// shared types and constants of the digit-count run-length codec
//------------------------------------------------------------------------------
`default_nettype none

package rlecdc_pkg;

   localparam logic [3:0] MAX_RUN    = 4'd9;
   localparam logic [3:0] MAX_DIGIT  = 4'd9;
   localparam logic [7:0] DIGIT_ZERO = 8'd48;
   localparam logic [7:0] DIGIT_NINE = 8'd57;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef enum logic {
      CMD_PAIRS  = 1'b0,
      CMD_COPIES = 1'b1
   } cmd_op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_word_type;

   // pairs: digit_a, byte_a, digit_b, byte_b (len 2 or 4); copies: byte_a len times
   typedef struct packed {
      cmd_op_type op;
      logic [7:0] digit_a;
      logic [7:0] byte_a;
      logic [7:0] digit_b;
      logic [7:0] byte_b;
      logic [3:0] len;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/rlecdc_front.sv
//------------------------------------------------------------------------------
// rlecdc_front
// accepts input words, keeps encode and decode state, issues emit commands
//------------------------------------------------------------------------------
`default_nettype none

module rlecdc_front import rlecdc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   input  wire logic         req_push,
   input  wire req_word_type req_word,
   output logic              req_full,
   input  wire logic         cmd_full,
   output logic              cmd_push,
   output cmd_type           cmd_word
);

   mode_type   mode_ff, mode_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [3:0] run_count_ff, run_count_in;
   logic       expect_letter_ff, expect_letter_in;
   logic [3:0] pair_count_ff, pair_count_in;

   logic       accept;
   logic [7:0] b;
   logic       fin;
   logic       flush_old;
   logic [3:0] new_count;
   logic [7:0] old_digit;
   logic [7:0] new_digit;
   logic [3:0] digit_off;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign b        = req_word.in_byte;
   assign fin      = req_word.is_final;

   assign flush_old = (run_count_ff != 4'd0) &&
                      !((b == held_byte_ff) && (run_count_ff < MAX_RUN));
   assign new_count = ((run_count_ff == 4'd0) || flush_old) ? 4'd1 : run_count_ff + 4'd1;
   assign old_digit = DIGIT_ZERO + {4'd0, run_count_ff};
   assign new_digit = DIGIT_ZERO + {4'd0, new_count};
   assign digit_off = b[3:0] - DIGIT_ZERO[3:0];

   always_comb begin
      mode_in          = mode_ff;
      held_byte_in     = held_byte_ff;
      run_count_in     = run_count_ff;
      expect_letter_in = expect_letter_ff;
      pair_count_in    = pair_count_ff;
      cmd_push         = 1'b0;
      cmd_word.op      = CMD_PAIRS;
      cmd_word.digit_a = flush_old ? old_digit : new_digit;
      cmd_word.byte_a  = flush_old ? held_byte_ff : b;
      cmd_word.digit_b = new_digit;
      cmd_word.byte_b  = b;
      cmd_word.len     = (flush_old && fin) ? 4'd4 : 4'd2;

      if (csr_we) begin
         mode_in = mode_type'(csr_wdata);
      end

      if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            cmd_push     = flush_old || fin;
            held_byte_in = fin ? 8'd0 : b;
            run_count_in = fin ? 4'd0 : new_count;
         end else if (!expect_letter_ff) begin
            if (fin) begin
               pair_count_in    = 4'd0;
               expect_letter_in = 1'b0;
            end else begin
               pair_count_in    = (b >= DIGIT_ZERO && b <= DIGIT_NINE) ? digit_off : 4'd0;
               expect_letter_in = 1'b1;
            end
         end else begin
            cmd_word.op      = CMD_COPIES;
            cmd_word.byte_a  = b;
            cmd_word.len     = pair_count_ff;
            cmd_push         = (pair_count_ff != 4'd0) && (pair_count_ff <= MAX_DIGIT);
            pair_count_in    = 4'd0;
            expect_letter_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_ENCODE;
         held_byte_ff     <= 8'd0;
         run_count_ff     <= 4'd0;
         expect_letter_ff <= 1'b0;
         pair_count_ff    <= 4'd0;
      end else begin
         mode_ff          <= mode_in;
         held_byte_ff     <= held_byte_in;
         run_count_ff     <= run_count_in;
         expect_letter_ff <= expect_letter_in;
         pair_count_ff    <= pair_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rlecdc_cmd_fifo.sv
//------------------------------------------------------------------------------
// rlecdc_cmd_fifo
// short command queue between front and back
//------------------------------------------------------------------------------
`default_nettype none

module rlecdc_cmd_fifo import rlecdc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_word,
   output logic          full,
   input  wire logic     pop,
   output cmd_type       pop_word,
   output logic          empty
);

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rlecdc_back.sv
//------------------------------------------------------------------------------
// rlecdc_back
// expands commands into an output register, one word per cycle unless stalled
//------------------------------------------------------------------------------
`default_nettype none

module rlecdc_back import rlecdc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     cmd_empty,
   input  wire cmd_type  cmd_word,
   output logic          cmd_pop,
   output logic          rsp_empty,
   output rsp_word_type  rsp_word,
   input  wire logic     rsp_pop
);

   logic         busy_ff, busy_in;
   cmd_type      cur_ff, cur_in;
   logic [3:0]   idx_ff, idx_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic         can_load;
   logic         is_last;
   logic [7:0]   sel_byte;

   assign can_load  = !out_valid_ff || rsp_pop;
   assign is_last   = (idx_ff == cur_ff.len - 4'd1);
   assign cmd_pop   = !busy_ff && !cmd_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      sel_byte = cur_ff.byte_a;
      if (cur_ff.op == CMD_PAIRS) begin
         case (idx_ff[1:0])
            2'd0:    sel_byte = cur_ff.digit_a;
            2'd1:    sel_byte = cur_ff.byte_a;
            2'd2:    sel_byte = cur_ff.digit_b;
            2'd3:    sel_byte = cur_ff.byte_b;
            default: sel_byte = cur_ff.byte_a;
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      if (busy_ff) begin
         if (can_load) begin
            out_valid_in    = 1'b1;
            out_in.out_byte = sel_byte;
            out_in.run_last = is_last;
            idx_in          = idx_ff + 4'd1;
            if (is_last) begin
               busy_in = 1'b0;
            end
         end
      end else if (!cmd_empty) begin
         busy_in = 1'b1;
         cur_in  = cmd_word;
         idx_in  = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rle_codec_digit_count.sv
//------------------------------------------------------------------------------
// rle_codec_digit_count
// byte-stream run-length codec with a single ascii digit as count
//------------------------------------------------------------------------------
// The front takes one input word per cycle while the command queue has room
// and updates the encode or decode state at once; the back then sends the
// resulting bytes out at one per cycle while the output register is free or
// read, after fetching each command. An encode word yields 0, 2 or 4 bytes,
// a decode letter up to 9 copies, so the sustained rate is bounded by the
// output side, and the two-entry queue lets the front run ahead of the back
// by two commands.
//------------------------------------------------------------------------------
`default_nettype none

module rle_codec_digit_count import rlecdc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata,
   input  wire logic         req_push,
   input  wire req_word_type req_word,
   output logic              req_full,
   output logic              rsp_empty,
   output rsp_word_type      rsp_word,
   input  wire logic         rsp_pop
);

   logic    cmd_push;
   cmd_type cmd_push_word;
   logic    cmd_full;
   logic    cmd_pop;
   cmd_type cmd_pop_word;
   logic    cmd_empty;

   rlecdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_word  (cmd_push_word)
   );

   rlecdc_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_word (cmd_push_word),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_word  (cmd_pop_word),
      .empty     (cmd_empty)
   );

   rlecdc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_word  (cmd_pop_word),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire
